/* rtl/fsa_pkg.sv */
// Shared types and constants for the free list slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

  // Fixed field widths of the item, result and size register
  localparam int unsigned OP_W    = 1;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;    // write one link entry of the rebuild pass
    logic capture;  // take the input beat and start the link read
    logic commit;   // update the pool and load the result register
  } fsa_cmd_t;

endpackage

`default_nettype wire

/* rtl/fsa_if.sv */
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface fsa_item_if;
  import fsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [INDEX_W-1:0]  release_index;

  modport source (output valid, op, release_index, input ready);
  modport sink   (input valid, op, release_index, output ready);
endinterface

interface fsa_result_if;
  import fsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [INDEX_W-1:0]  granted_index;
  logic [COUNT_W-1:0]  usage;
  logic [COUNT_W-1:0]  usage_peak;

  modport source (output valid, status, granted_index, usage, usage_peak, input ready);
  modport sink   (input valid, status, granted_index, usage, usage_peak, output ready);
endinterface

`default_nettype wire

/* rtl/free_list_slot_allocator.sv */
// Top level: LIFO free list slot allocator over a fixed pool.
// A request beat is captured on acceptance with the head's link read, and the
// result register loads on commit, which waits while a held result is not taken.
// No new request is taken before the last commits, as the synchronous link memory
// read must finish first. Reset: all slots free, head at capacity-1, then a pass over
// every link entry rebuilds the chain with input held off. A size write does the same for its clamped size.
`timescale 1ns / 1ps
`default_nettype none

module free_list_slot_allocator #(
  parameter int unsigned SLOT_CAPACITY = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  fsa_item_if.sink                          item,
  fsa_result_if.source                      result,
  input  wire logic                         cfg_we,
  input  wire logic [fsa_pkg::COUNT_W-1:0]  cfg_data
);
  import fsa_pkg::*;

  fsa_cmd_t cmd;
  logic     clear_last;

  // Sequencing
  fsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .clear_last (clear_last),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .cmd        (cmd)
  );

  // Pool storage and arithmetic
  fsa_datapath #(
    .SLOT_CAPACITY (SLOT_CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (item.op),
    .release_index (item.release_index),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .clear_last    (clear_last),
    .status        (result.status),
    .granted_index (result.granted_index),
    .usage         (result.usage),
    .usage_peak    (result.usage_peak)
  );

endmodule

`default_nettype wire

/* rtl/fsa_ctrl.sv */
// Controller: sequences the rebuild pass, accept, link read and commit, owns result valid.
`timescale 1ns / 1ps
`default_nettype none

module fsa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             clear_last,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fsa_pkg::fsa_cmd_t     cmd
);
  import fsa_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  // State and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid & ~out_ready;
    case (state)
      S_CLEAR: begin
        // rebuild the link chain one entry per cycle
        cmd.clear = 1'b1;
        if (clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = ~cfg_we;
        if (in_valid && !cfg_we) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register is free or drains this cycle
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a size write restarts the rebuild pass
    if (cfg_we) begin
      state_next = S_CLEAR;
    end
  end

endmodule

`default_nettype wire

/* rtl/fsa_datapath.sv */
// Datapath: link memory, list head, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module fsa_datapath #(
  parameter int unsigned SLOT_CAPACITY = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fsa_pkg::fsa_cmd_t             cmd,
  input  wire logic [fsa_pkg::OP_W-1:0]      op,
  input  wire logic [fsa_pkg::INDEX_W-1:0]   release_index,
  input  wire logic                          cfg_we,
  input  wire logic [fsa_pkg::COUNT_W-1:0]   cfg_data,
  output logic                               clear_last,
  output logic [1:0]                         status,
  output logic [fsa_pkg::INDEX_W-1:0]        granted_index,
  output logic [fsa_pkg::COUNT_W-1:0]        usage,
  output logic [fsa_pkg::COUNT_W-1:0]        usage_peak
);
  import fsa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOT_CAPACITY);
  localparam int unsigned CNT_W  = $clog2(SLOT_CAPACITY + 1);

  logic [SLOT_W-1:0] link_mem [SLOT_CAPACITY];
  logic [SLOT_W-1:0] link_rd;

  // Pool state
  logic [CNT_W-1:0]  pool_size;
  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  usage_count;
  logic [CNT_W-1:0]  peak_count;
  logic [SLOT_W-1:0] clr_addr;

  // Captured beat
  logic [OP_W-1:0]    op_q;
  logic [INDEX_W-1:0] index_q;

  // Next values
  logic [CNT_W-1:0]  pool_clamped;
  logic [SLOT_W-1:0] head_next;
  logic [CNT_W-1:0]  free_next;
  logic [CNT_W-1:0]  usage_next;
  logic [CNT_W-1:0]  peak_next;
  status_t           status_next;
  logic [SLOT_W-1:0] granted_next;
  logic              link_we;
  logic [SLOT_W-1:0] release_slot;

  // Clamp a written size into 1..capacity
  always_comb begin
    if (cfg_data == '0) begin
      pool_clamped = CNT_W'(1);
    end else if (32'(cfg_data) > SLOT_CAPACITY) begin
      pool_clamped = CNT_W'(SLOT_CAPACITY);
    end else begin
      pool_clamped = CNT_W'(cfg_data);
    end
  end

  assign release_slot = SLOT_W'(index_q);
  assign clear_last   = (clr_addr == SLOT_W'(SLOT_CAPACITY - 1));

  // Acquire pops the head, release pushes the captured index
  always_comb begin
    head_next    = head;
    free_next    = free_count;
    usage_next   = usage_count;
    peak_next    = peak_count;
    status_next  = ST_OK;
    granted_next = '0;
    link_we      = 1'b0;
    if (op_t'(op_q) == OP_ACQUIRE) begin
      if (free_count == '0) begin
        status_next = ST_EXHAUSTED;
      end else begin
        granted_next = head;
        head_next    = link_rd;
        free_next    = free_count - CNT_W'(1);
        if (usage_count < pool_size) begin
          usage_next = usage_count + CNT_W'(1);
        end
        if (usage_next > peak_count) begin
          peak_next = usage_next;
        end
      end
    end else begin
      if (32'(index_q) >= 32'(pool_size)) begin
        status_next = ST_RANGE;
      end else begin
        link_we   = 1'b1;
        head_next = release_slot;
        if (free_count < pool_size) begin
          free_next = free_count + CNT_W'(1);
        end
        if (usage_count != '0) begin
          usage_next = usage_count - CNT_W'(1);
        end
      end
    end
  end

  // Pool state: rebuilt on reset and on a size write
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= CNT_W'(SLOT_CAPACITY);
      head        <= SLOT_W'(SLOT_CAPACITY - 1);
      free_count  <= CNT_W'(SLOT_CAPACITY);
      usage_count <= '0;
      peak_count  <= '0;
    end else if (cfg_we) begin
      pool_size   <= pool_clamped;
      head        <= SLOT_W'(pool_clamped - CNT_W'(1));
      free_count  <= pool_clamped;
      usage_count <= '0;
      peak_count  <= '0;
    end else if (cmd.commit) begin
      head        <= head_next;
      free_count  <= free_next;
      usage_count <= usage_next;
      peak_count  <= peak_next;
    end
  end

  // Rebuild pass address
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  // Beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      index_q <= release_index;
    end
  end

  // Link memory: chain i -> i-1 during the rebuild pass, head's link read on
  // capture, pushed link written on a release commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      link_rd <= link_mem[head];
    end
    if (cmd.clear) begin
      link_mem[clr_addr] <= (clr_addr == '0) ? '0 : clr_addr - SLOT_W'(1);
    end else if (cmd.commit && link_we) begin
      link_mem[release_slot] <= head;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= status_next;
      granted_index <= INDEX_W'(32'(granted_next));
      usage         <= COUNT_W'(32'(usage_next));
      usage_peak    <= COUNT_W'(32'(peak_next));
    end
  end

endmodule

`default_nettype wire
